// ===== hw/rtl/ltok_pkg.sv =====
`timescale 1ns / 1ps

package ltok_pkg;

  // Byte classes seen by the reader.
  typedef enum logic [2:0] {
    CLS_WS,
    CLS_CONST,
    CLS_SESC,
    CLS_MESC,
    CLS_TMAC,
    CLS_NMAC,
    CLS_BAD
  } cls_t;

  // Result event codes.
  localparam logic [2:0] EV_CHAR  = 3'd0;
  localparam logic [2:0] EV_DONE  = 3'd1;
  localparam logic [2:0] EV_MACRO = 3'd2;
  localparam logic [2:0] EV_RERR  = 3'd3;
  localparam logic [2:0] EV_EOF   = 3'd4;

  // Case conversion modes.
  localparam logic [1:0] CM_UPCASE   = 2'd0;
  localparam logic [1:0] CM_DOWNCASE = 2'd1;
  localparam logic [1:0] CM_PRESERVE = 2'd2;
  localparam logic [1:0] CM_INVERT   = 2'd3;

  // Configuration register indexes.
  localparam logic REG_CASE_MODE   = 1'b0;
  localparam logic REG_MACRO_SLOTS = 1'b1;

  // Fixed syntax characters.
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SESC = 8'h27;
  localparam logic [7:0] CH_MESC = 8'h7C;

  localparam int         SLOTS   = 8;
  localparam logic [62:0] VAL_MAX = {63{1'b1}};

  // One classified input item, front to back.
  typedef struct packed {
    logic [7:0] chr;
    logic       at_end;
    cls_t       cls;
  } item_t;

  // Results caused by one item: a first result, and optionally a
  // trailing macro character event.
  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  chr;
    logic        num;
    logic [62:0] val;
    logic        two;
    logic [7:0]  mac;
  } bundle_t;

endpackage

// ===== hw/rtl/ltok_fifo.sv =====
`timescale 1ns / 1ps

module ltok_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [Width-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [Width-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/ltok_front.sv =====
`timescale 1ns / 1ps

module ltok_front #(
  parameter int Depth = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          in_byte,
  input  logic                at_end,
  input  logic [63:0]         macro_char_slots,
  output logic                full,
  input  logic                rd_en,
  output ltok_pkg::item_t     item,
  output logic                item_valid
);

  import ltok_pkg::*;

  item_t wr_item;
  logic  empty;

  // Sort a byte into its reader class. The hash mark is always a
  // non-terminating macro; a configured slot wins over all else but the hash.
  function automatic cls_t classify(input logic [7:0] c, input logic [63:0] slots);
    logic hit;
    cls_t r;
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slots[i*8 +: 8] != 8'h00 && slots[i*8 +: 8] == c) begin
        hit = 1'b1;
      end
    end
    if (c == CH_HASH) begin
      r = CLS_NMAC;
    end else if (hit) begin
      r = CLS_TMAC;
    end else if (c inside {8'd9, 8'd10, 8'd12, 8'd13, 8'd32}) begin
      r = CLS_WS;
    end else if (c == CH_SESC) begin
      r = CLS_SESC;
    end else if (c == CH_MESC) begin
      r = CLS_MESC;
    end else if (c inside {8'd8, "!", "$", "%", "&", "*", "+", "-", ".", "/", ":",
                           "<", "=", ">", "?", "@", "[", "]", "^", "_", "{", "}",
                           "~", ["0":"9"], ["a":"z"], ["A":"Z"]}) begin
      r = CLS_CONST;
    end else begin
      r = CLS_BAD;
    end
    return r;
  endfunction

  // Classify on the way into the queue.
  always_comb begin
    wr_item.chr    = in_byte;
    wr_item.at_end = at_end;
    wr_item.cls    = classify(in_byte, macro_char_slots);
  end

  ltok_fifo #(
    .Width ($bits(item_t)),
    .Depth (Depth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (wr_item),
    .full    (full),
    .rd_en   (rd_en),
    .rd_data (item),
    .empty   (empty)
  );

  assign item_valid = !empty;

endmodule

// ===== hw/rtl/ltok_back.sv =====
`timescale 1ns / 1ps

module ltok_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        case_mode,
  input  ltok_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_take,
  input  logic              res_full,
  output logic              res_we,
  output ltok_pkg::bundle_t res
);

  import ltok_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE,
    M_TOK,
    M_MULTI,
    M_ESC_TOK,
    M_ESC_MULTI
  } mode_t;

  mode_t       mode;
  mode_t       mode_next;
  logic        esc;
  logic        esc_next;
  logic        dig;
  logic        dig_next;
  logic [62:0] val;
  logic [62:0] val_next;

  logic        fire;
  logic [7:0]  cc;
  logic        is_up;
  logic        is_lo;
  logic        dec_char;
  logic [66:0] acc_wide;
  logic [62:0] acc_sat;
  logic        num_ok;
  logic        take_char;
  logic        take_done;
  logic        take_fail;
  logic        take_mac;
  logic        add_mac;
  logic [2:0]  fail_ev;

  assign fire      = item_valid && !res_full;
  assign item_take = fire;

  // Case conversion touches letters only.
  always_comb begin
    is_up = item.chr inside {["A":"Z"]};
    is_lo = item.chr inside {["a":"z"]};
    cc    = item.chr;
    case (case_mode)
      CM_UPCASE:   cc = is_lo ? item.chr - 8'd32 : item.chr;
      CM_DOWNCASE: cc = is_up ? item.chr + 8'd32 : item.chr;
      CM_PRESERVE: cc = item.chr;
      CM_INVERT: begin
        if (is_up) begin
          cc = item.chr + 8'd32;
        end else if (is_lo) begin
          cc = item.chr - 8'd32;
        end
      end
      default: cc = item.chr;
    endcase
  end

  // Decimal accumulate: times ten by shift and add, then saturate.
  assign dec_char = cc inside {["0":"9"]};
  assign acc_wide = 67'({val, 3'b000}) + 67'({val, 1'b0}) + 67'(cc[3:0]);
  assign acc_sat  = (acc_wide[66:63] != 4'd0) ? VAL_MAX : acc_wide[62:0];
  assign num_ok   = dig && !esc;

  // Reader transitions for one item.
  always_comb begin
    mode_next = mode;
    esc_next  = esc;
    dig_next  = dig;
    val_next  = val;
    take_char = 1'b0;
    take_done = 1'b0;
    take_fail = 1'b0;
    take_mac  = 1'b0;
    add_mac   = 1'b0;
    fail_ev   = EV_RERR;
    res       = '0;
    res_we    = 1'b0;

    if (fire) begin
      case (mode)
        M_TOK: begin
          if (item.at_end) begin
            take_done = 1'b1;
          end else begin
            case (item.cls)
              CLS_CONST, CLS_NMAC: take_char = 1'b1;
              CLS_SESC: begin
                esc_next  = 1'b1;
                mode_next = M_ESC_TOK;
              end
              CLS_MESC: begin
                esc_next  = 1'b1;
                mode_next = M_MULTI;
              end
              CLS_TMAC: begin
                take_done = 1'b1;
                add_mac   = 1'b1;
              end
              CLS_WS:  take_done = 1'b1;
              default: take_fail = 1'b1;
            endcase
          end
        end
        M_MULTI: begin
          if (item.at_end) begin
            take_fail = 1'b1;
            fail_ev   = EV_EOF;
          end else begin
            case (item.cls)
              CLS_SESC: begin
                esc_next  = 1'b1;
                mode_next = M_ESC_MULTI;
              end
              CLS_MESC: begin
                esc_next  = 1'b1;
                mode_next = M_TOK;
              end
              CLS_BAD: take_fail = 1'b1;
              default: take_char = 1'b1;
            endcase
          end
        end
        M_ESC_TOK, M_ESC_MULTI: begin
          if (item.at_end) begin
            take_fail = 1'b1;
            fail_ev   = EV_EOF;
          end else begin
            take_char = 1'b1;
            esc_next  = 1'b1;
            mode_next = (mode == M_ESC_TOK) ? M_TOK : M_MULTI;
          end
        end
        default: begin
          mode_next = M_IDLE;
          if (item.at_end) begin
            take_fail = 1'b1;
            fail_ev   = EV_EOF;
          end else begin
            case (item.cls)
              CLS_TMAC, CLS_NMAC: take_mac = 1'b1;
              CLS_SESC: begin
                esc_next  = 1'b1;
                mode_next = M_ESC_TOK;
              end
              CLS_MESC: begin
                esc_next  = 1'b1;
                mode_next = M_MULTI;
              end
              CLS_CONST: begin
                take_char = 1'b1;
                mode_next = M_TOK;
              end
              CLS_WS:  mode_next = M_IDLE;
              default: take_fail = 1'b1;
            endcase
          end
        end
      endcase
    end

    // Token character: fold into the running value and type.
    if (take_char) begin
      res_we   = 1'b1;
      res.ev   = EV_CHAR;
      res.chr  = cc;
      dig_next = dig && dec_char;
      val_next = dec_char ? acc_sat : val;
    end

    // Macro character seen outside a token.
    if (take_mac) begin
      res_we  = 1'b1;
      res.ev  = EV_MACRO;
      res.chr = item.chr;
    end

    // Token end, with an optional trailing macro event.
    if (take_done) begin
      res_we    = 1'b1;
      res.ev    = EV_DONE;
      res.num   = num_ok;
      res.val   = num_ok ? val : '0;
      res.two   = add_mac;
      res.mac   = item.chr;
      esc_next  = 1'b0;
      dig_next  = 1'b1;
      val_next  = '0;
      mode_next = M_IDLE;
    end

    // Error drops the token.
    if (take_fail) begin
      res_we    = 1'b1;
      res.ev    = fail_ev;
      esc_next  = 1'b0;
      dig_next  = 1'b1;
      val_next  = '0;
      mode_next = M_IDLE;
    end
  end

  // Reader state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      esc  <= 1'b0;
      dig  <= 1'b1;
      val  <= '0;
    end else begin
      mode <= mode_next;
      esc  <= esc_next;
      dig  <= dig_next;
      val  <= val_next;
    end
  end

endmodule

// ===== hw/rtl/lisp_reader_tokenizer_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         push / full        in_byte, at_end
// result    out        empty / pop        event_res, out_char, is_number,
//                                          number_value, last
// config    in         cfg_we             cfg_index, cfg_data
//
// The input queue takes one item per cycle while not full; the reader
// retires one item per cycle whenever the result queue has a free entry.
// Each result passes the registered input queue, then the result queue.
// Results leave one per cycle while pop is held, so an item that causes two
// results takes two pops; the result queue absorbs that as input flows on.
// Synchronous reset empties both queues, returns the reader to idle, and
// sets case mode to upcase with no macro slots.
// full rises when the input queue holds MidDepth items; the reader halts
// while the result queue is full.
module lisp_reader_tokenizer_top #(
  parameter int MidDepth = 2,
  parameter int OutDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        at_end,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_res,
  output logic [7:0]  out_char,
  output logic        is_number,
  output logic [62:0] number_value,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  import ltok_pkg::*;

  logic [1:0]  case_mode;
  logic [63:0] macro_char_slots;

  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    res_we;
  logic    res_full;
  bundle_t res;
  bundle_t head;
  logic    second;
  logic    head_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      case_mode        <= CM_UPCASE;
      macro_char_slots <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CASE_MODE:   case_mode        <= cfg_data[1:0];
        REG_MACRO_SLOTS: macro_char_slots <= cfg_data;
        default:         case_mode        <= case_mode;
      endcase
    end
  end

  ltok_front #(
    .Depth (MidDepth)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .in_byte          (in_byte),
    .at_end           (at_end),
    .macro_char_slots (macro_char_slots),
    .full             (full),
    .rd_en            (item_take),
    .item             (item),
    .item_valid       (item_valid)
  );

  ltok_back u_back (
    .clk        (clk),
    .rst        (rst),
    .case_mode  (case_mode),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .res_full   (res_full),
    .res_we     (res_we),
    .res        (res)
  );

  ltok_fifo #(
    .Width ($bits(bundle_t)),
    .Depth (OutDepth)
  ) u_results (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_we),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (head_take),
    .rd_data (head),
    .empty   (empty)
  );

  // An entry with a trailing macro event is shown twice before it leaves.
  assign head_take = pop && !empty && (second || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (pop && !empty) begin
      second <= head.two && !second;
    end
  end

  // Result ports.
  always_comb begin
    if (second) begin
      event_res    = EV_MACRO;
      out_char     = head.mac;
      is_number    = 1'b0;
      number_value = '0;
      last         = 1'b1;
    end else begin
      event_res    = head.ev;
      out_char     = head.chr;
      is_number    = head.num;
      number_value = head.val;
      last         = !head.two;
    end
  end

  // The second half of an entry is only ever shown for a two-result entry.
  a_second_needs_pair: assert property (@(posedge clk) disable iff (rst)
    second |-> (!empty && head.two))
    else $error("trailing macro shown without a two-result entry");

  // The reader never writes into a full result queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_we |-> !res_full)
    else $error("result queue written while full");

  // A two-result entry always leads with a token-done event.
  a_pair_is_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && head.two) |-> (head.ev == EV_DONE))
    else $error("two-result entry without token done");

  // A popped first half of a pair is followed by its macro half.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && head.two && !second) |=> (second && event_res == EV_MACRO))
    else $error("macro half of a pair did not follow");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ltok_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 100;

  // Reader modes of the predictor.
  typedef enum logic [2:0] {
    RM_IDLE,
    RM_TOKEN,
    RM_MULTI,
    RM_ESC_TOKEN,
    RM_ESC_MULTI
  } rmode_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  chr;
    logic        num;
    logic [62:0] val;
    logic        last;
  } event_t;

  // One directed input; the result is typed in only where typed is set.
  typedef struct {
    logic [7:0]  chr;
    logic        at_end;
    logic        typed;
    logic [2:0]  ev;
    logic [7:0]  rchr;
    logic        num;
    logic [62:0] val;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = '0;
  logic        at_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  out_char;
  logic        is_number;
  logic [62:0] number_value;
  logic        last;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  // Predictor state and configuration.
  rmode_t      rd_mode = RM_IDLE;
  logic        tok_escaped = 1'b0;
  logic        tok_digits = 1'b1;
  logic [62:0] tok_value = '0;
  logic [1:0]  case_cfg = CM_UPCASE;
  logic [63:0] slot_cfg = '0;

  event_t      byte_events[$];
  event_t      awaited[$];
  event_t      head;
  logic [8:0]  feed[$];
  logic        calm = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  string       sym_chars = "!$%&*+-./:<=>?@[]^_{}~#";
  logic [7:0]  ws_chars [5] = '{8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20};

  // Settings walked through after the reset phase.
  logic [1:0]  mode_steps [5] = '{CM_DOWNCASE, CM_PRESERVE, CM_INVERT, CM_INVERT, CM_UPCASE};
  logic [63:0] slot_steps [5] = '{
    64'h0000_2C60_223B_2928,
    {"#", " ", "a", "'", "(", ")", "5", 8'h00},
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h0,
    64'h0
  };

  row_t script [25] = '{
    // End of input while idle.
    '{8'h00, 1'b1, 1'b1, EV_EOF,   8'h00, 1'b0, 63'd0},
    // A short symbol; the reset mode upcases, 'z' included.
    '{"a",   1'b0, 1'b1, EV_CHAR,  "A",   1'b0, 63'd0},
    '{"z",   1'b0, 1'b1, EV_CHAR,  "Z",   1'b0, 63'd0},
    '{" ",   1'b0, 1'b1, EV_DONE,  8'h00, 1'b0, 63'd0},
    // A number closed by end of input.
    '{"1",   1'b0, 1'b1, EV_CHAR,  "1",   1'b0, 63'd0},
    '{"2",   1'b0, 1'b1, EV_CHAR,  "2",   1'b0, 63'd0},
    '{8'hFF, 1'b1, 1'b1, EV_DONE,  8'h00, 1'b1, 63'd12},
    // A hash while idle is handed out as a macro character.
    '{"#",   1'b0, 1'b1, EV_MACRO, "#",   1'b0, 63'd0},
    '{8'h00, 1'b0, 1'b1, EV_RERR,  8'h00, 1'b0, 63'd0},
    // Leading single escape takes an invalid byte literally.
    '{"'",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{"(",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{"7",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{8'h09, 1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    // Multiple escape with an escaped bar, then a hash inside a token.
    '{"|",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{"b",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{"'",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{"|",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{"|",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{"#",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{8'hFF, 1'b0, 1'b1, EV_RERR,  8'h00, 1'b0, 63'd0},
    // End of input inside a multiple escape and inside a single escape.
    '{"|",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{8'h80, 1'b1, 1'b1, EV_EOF,   8'h00, 1'b0, 63'd0},
    '{"x",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{"'",   1'b0, 1'b0, EV_CHAR,  8'h00, 1'b0, 63'd0},
    '{8'h55, 1'b1, 1'b1, EV_EOF,   8'h00, 1'b0, 63'd0}
  };

  lisp_reader_tokenizer_top uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .at_end       (at_end),
    .empty        (empty),
    .pop          (pop),
    .event_res    (event_res),
    .out_char     (out_char),
    .is_number    (is_number),
    .number_value (number_value),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Byte classes under the current macro slots; the hash is never terminating.
  function automatic cls_t classify(logic [7:0] c);
    int i;
    if (c == CH_HASH) return CLS_NMAC;
    for (i = 0; i < SLOTS; i++) begin
      if (slot_cfg[8 * i +: 8] != 8'h00 && slot_cfg[8 * i +: 8] == c) return CLS_TMAC;
    end
    case (c)
      8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20: return CLS_WS;
      CH_SESC: return CLS_SESC;
      CH_MESC: return CLS_MESC;
      8'h08, "!", "$", "%", "&", "*", "+", "-", ".", "/", ":", "<", "=", ">", "?",
      "@", "[", "]", "^", "_", "{", "}", "~": return CLS_CONST;
      default: ;
    endcase
    if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
      return CLS_CONST;
    return CLS_BAD;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    logic up;
    logic lo;
    up = c >= "A" && c <= "Z";
    lo = c >= "a" && c <= "z";
    if (!up && !lo) return c;
    case (case_cfg)
      CM_UPCASE:   return lo ? c - 8'd32 : c;
      CM_DOWNCASE: return up ? c + 8'd32 : c;
      CM_PRESERVE: return c;
      default:     return up ? c + 8'd32 : c - 8'd32;
    endcase
  endfunction

  function automatic void note(logic [2:0] ev, logic [7:0] c, logic num, logic [62:0] v);
    byte_events.push_back('{ev, c, num, v, 1'b0});
  endfunction

  function automatic void clear_token();
    tok_escaped = 1'b0;
    tok_digits = 1'b1;
    tok_value = '0;
  endfunction

  // Emit one token character and fold it into the saturating decimal value.
  function automatic void take_char(logic [7:0] c);
    logic [7:0]  cc;
    logic [63:0] d;
    cc = fold_case(c);
    if (cc >= "0" && cc <= "9") begin
      d = 64'(cc - "0");
      if (64'(tok_value) > (64'(VAL_MAX) - d) / 64'd10) tok_value = VAL_MAX;
      else tok_value = 63'(64'(tok_value) * 64'd10 + d);
    end else begin
      tok_digits = 1'b0;
    end
    note(EV_CHAR, cc, 1'b0, '0);
  endfunction

  function automatic void close_token();
    logic num;
    num = tok_digits && !tok_escaped;
    note(EV_DONE, 8'h00, num, num ? tok_value : 63'd0);
    clear_token();
    rd_mode = RM_IDLE;
  endfunction

  function automatic void drop_token(logic [2:0] ev);
    note(ev, 8'h00, 1'b0, '0);
    clear_token();
    rd_mode = RM_IDLE;
  endfunction

  // Advance the reader by one input and collect the results it causes.
  function automatic void read_byte(logic [7:0] c, logic e);
    cls_t k;
    byte_events.delete();
    k = classify(c);
    case (rd_mode)
      RM_TOKEN: begin
        if (e) close_token();
        else if (k == CLS_CONST || k == CLS_NMAC) take_char(c);
        else if (k == CLS_SESC) begin
          tok_escaped = 1'b1;
          rd_mode = RM_ESC_TOKEN;
        end else if (k == CLS_MESC) begin
          tok_escaped = 1'b1;
          rd_mode = RM_MULTI;
        end else if (k == CLS_BAD) drop_token(EV_RERR);
        else if (k == CLS_TMAC) begin
          close_token();
          note(EV_MACRO, c, 1'b0, '0);
        end else close_token();
      end
      RM_MULTI: begin
        if (e) drop_token(EV_EOF);
        else if (k == CLS_SESC) begin
          tok_escaped = 1'b1;
          rd_mode = RM_ESC_MULTI;
        end else if (k == CLS_MESC) begin
          tok_escaped = 1'b1;
          rd_mode = RM_TOKEN;
        end else if (k == CLS_BAD) drop_token(EV_RERR);
        else take_char(c);
      end
      RM_ESC_TOKEN, RM_ESC_MULTI: begin
        if (e) drop_token(EV_EOF);
        else begin
          take_char(c);
          tok_escaped = 1'b1;
          rd_mode = (rd_mode == RM_ESC_TOKEN) ? RM_TOKEN : RM_MULTI;
        end
      end
      default: begin
        rd_mode = RM_IDLE;
        if (e) drop_token(EV_EOF);
        else if (k == CLS_BAD) drop_token(EV_RERR);
        else if (k == CLS_TMAC || k == CLS_NMAC) note(EV_MACRO, c, 1'b0, '0);
        else if (k == CLS_SESC) begin
          tok_escaped = 1'b1;
          rd_mode = RM_ESC_TOKEN;
        end else if (k == CLS_MESC) begin
          tok_escaped = 1'b1;
          rd_mode = RM_MULTI;
        end else if (k == CLS_CONST) begin
          take_char(c);
          rd_mode = RM_TOKEN;
        end
      end
    endcase
    if (byte_events.size() != 0) byte_events[byte_events.size() - 1].last = 1'b1;
  endfunction

  // Random stimulus helpers.
  function automatic logic [7:0] any_constituent();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 35) return "a" + 8'($urandom_range(25));
    if (k < 65) return "A" + 8'($urandom_range(25));
    if (k < 85) return "0" + 8'($urandom_range(9));
    if (k == 99) return 8'h08;
    return sym_chars[$urandom_range(sym_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] macro_or_space();
    logic [7:0] s;
    int i;
    for (i = 0; i < 16; i++) begin
      s = slot_cfg[8 * $urandom_range(7) +: 8];
      if (s != 8'h00) return s;
    end
    return ws_chars[$urandom_range(4)];
  endfunction

  task automatic add(input logic [7:0] b, input logic e);
    feed.push_back({e, b});
  endtask

  task automatic add_end_of_token();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 45) add(ws_chars[$urandom_range(4)], 1'b0);
    else if (k < 70) add(macro_or_space(), 1'b0);
    else if (k < 85) add(8'($urandom), 1'b1);
    else add(8'($urandom), 1'b0);
  endtask

  // One well-formed piece of text with random content, or a bit of noise.
  task automatic add_sequence();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(99);
    if (kind < 30) begin
      // Symbol token, now and then with escaped pieces inside.
      len = $urandom_range(1, 8);
      repeat (len) begin
        case ($urandom_range(9))
          0: begin
            add("'", 1'b0);
            add(8'($urandom), 1'b0);
          end
          1: begin
            add("|", 1'b0);
            repeat ($urandom_range(0, 3)) add(any_constituent(), 1'b0);
            add("|", 1'b0);
          end
          default: add(any_constituent(), 1'b0);
        endcase
      end
      add_end_of_token();
    end else if (kind < 50) begin
      // Decimal token; about one in four is 17 to 24 digits long and may saturate.
      len = ($urandom_range(3) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 6);
      repeat (len) add("0" + 8'($urandom_range(9)), 1'b0);
      add_end_of_token();
    end else if (kind < 62) begin
      // Leading single escape on any byte.
      add("'", 1'b0);
      add(8'($urandom), 1'b0);
      repeat ($urandom_range(0, 3)) add(any_constituent(), 1'b0);
      add_end_of_token();
    end else if (kind < 74) begin
      // Multiple escape around mixed content; sometimes cut off by end of input.
      add("|", 1'b0);
      repeat ($urandom_range(0, 4))
        add(($urandom_range(3) == 0) ? 8'($urandom) : any_constituent(), 1'b0);
      if ($urandom_range(4) == 0) add(8'($urandom), 1'b1);
      else begin
        add("|", 1'b0);
        add_end_of_token();
      end
    end else if (kind < 84) begin
      // Macro characters between tokens.
      add(($urandom_range(1) == 0) ? CH_HASH : macro_or_space(), 1'b0);
      add(ws_chars[$urandom_range(4)], 1'b0);
    end else begin
      repeat ($urandom_range(1, 3)) add(8'($urandom), $urandom_range(7) == 0);
    end
  endtask

  // One input transfer; entered and left at a falling edge.
  task automatic send_item(input logic [7:0] b, input logic e, input logic typed,
                           input event_t want);
    while (!calm && $urandom_range(99) < 35) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    at_end <= e;
    do @(posedge clk); while (full);
    read_byte(b, e);
    if (typed) awaited.push_back(want);
    else foreach (byte_events[i]) awaited.push_back(byte_events[i]);
    @(negedge clk);
  endtask

  task automatic run_random(input int unsigned count);
    logic [8:0] next_in;
    while (feed.size() < count) add_sequence();
    while (feed.size() != 0) begin
      next_in = feed.pop_front();
      send_item(next_in[7:0], next_in[8], 1'b0, '0);
    end
  endtask

  // Let every result drain and the reader go quiet before touching registers.
  task automatic settle();
    push <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_reader(input logic [1:0] mode, input logic [63:0] slots);
    cfg_we <= 1'b1;
    cfg_index <= REG_CASE_MODE;
    cfg_data <= {$urandom, 30'($urandom), mode};
    @(posedge clk);
    case_cfg = mode;
    @(negedge clk);
    cfg_index <= REG_MACRO_SLOTS;
    cfg_data <= slots;
    @(posedge clk);
    slot_cfg = slots;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result side stalls at random except in the calm phase.
  always @(negedge clk) begin
    pop <= calm || ($urandom_range(99) >= 35);
  end

  // Compare each result transfer with the oldest expected result.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result event_res=%0d out_char=%h is_number=%b value=%0d",
                 $time, event_res, out_char, is_number, number_value);
        errors++;
      end else begin
        head = awaited.pop_front();
        check_field("event_res", 64'(head.ev), 64'(event_res));
        check_field("out_char", 64'(head.chr), 64'(out_char));
        check_field("is_number", 64'(head.num), 64'(is_number));
        check_field("number_value", 64'(head.val), 64'(number_value));
        check_field("last", 64'(head.last), 64'(last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    event_t want;
    logic [63:0] slots;
    int p;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed inputs under the reset settings.
    foreach (script[i]) begin
      want = '{script[i].ev, script[i].rchr, script[i].num, script[i].val, 1'b1};
      send_item(script[i].chr, script[i].at_end, script[i].typed, want);
    end
    run_random(PHASE_ITEMS);

    // Random text under each further setting; the second one runs without idling.
    for (p = 0; p < 5; p++) begin
      settle();
      slots = (p == 3) ? {$urandom, $urandom} : slot_steps[p];
      set_reader(mode_steps[p], slots);
      calm = (p == 1);
      run_random(PHASE_ITEMS);
    end
    calm = 1'b0;
    settle();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== lisp_reader_tokenizer_top.f =====
hw/rtl/ltok_pkg.sv
hw/rtl/ltok_fifo.sv
hw/rtl/ltok_front.sv
hw/rtl/ltok_back.sv
hw/rtl/lisp_reader_tokenizer_top.sv
test/tb_top.sv
